[rtl/jaad_pkg.sv]
// Shared types and constants of the joystick axis average and dead band block.
package jaad_pkg;

   localparam int SAMPLE_W = 12;   // converter sample and centre width
   localparam int AXIS_W   = 9;    // signed deflection width
   localparam int AXES     = 4;    // left h, left v, right h, right v
   localparam int DIVD_W   = 20;   // divider dividend width (v*255 < 2^20)
   localparam int CNT_W    = 4;    // divider step counter width

   localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 12'd4095;
   localparam logic [SAMPLE_W-1:0] CENTRE_RESET  = 12'd2048;
   localparam logic [AXIS_W-1:0]   SPAN          = 9'd255;
   localparam logic [CNT_W-1:0]    DEFL_STEPS    = 4'd8;   // quotient bits of the deflection

   // configuration register indexes
   localparam logic [1:0] CSR_CENTRE_LEFT_H  = 2'd0;
   localparam logic [1:0] CSR_CENTRE_LEFT_V  = 2'd1;
   localparam logic [1:0] CSR_CENTRE_RIGHT_H = 2'd2;
   localparam logic [1:0] CSR_CENTRE_RIGHT_V = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVG_GO,
      ST_AVG_RUN,
      ST_DEFL_RUN,
      ST_DONE
   } state_type;

   // commands from the sequencer to the axis lanes
   typedef struct packed {
      logic start_avg;
      logic start_defl;
   } lane_ctrl_type;

endpackage

[rtl/jaad_lane.sv]
// One axis lane: dead band selection and serial divider for the scaled deflection.
module jaad_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  jaad_pkg::lane_ctrl_type         ctrl,
   input  logic [jaad_pkg::SAMPLE_W-1:0]   avg,
   input  logic [jaad_pkg::SAMPLE_W-1:0]   centre,
   input  logic                            invert,
   output logic                            busy,
   output logic signed [jaad_pkg::AXIS_W-1:0] deflection
);
   import jaad_pkg::*;

   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [SAMPLE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                lower_ff, lower_in;
   logic                upper_ff, upper_in;

   logic [SAMPLE_W-1:0] v;
   logic [SAMPLE_W:0]   v_ext, c_ext;
   logic                below, above;
   logic [SAMPLE_W-1:0] diff;
   logic [DIVD_W-1:0]   prod;
   logic [SAMPLE_W:0]   trial;
   logic                fits;
   logic [AXIS_W-1:0]   qmag;

   // branch selection on the finished average
   always_comb begin
      v     = invert ? (FULL_SCALE - quo_ff) : quo_ff;
      v_ext = {1'b0, v};
      c_ext = {1'b0, centre};
      below = (v_ext + 13'd1) < c_ext;
      above = v_ext > (c_ext + 13'd1);
      diff  = below ? v : (v - centre);
      // x*255 as x*256 - x
      prod  = {diff, 8'b0} - {8'b0, diff};
   end

   // restoring divider step and loads
   always_comb begin
      trial    = {rem_ff, quo_ff[SAMPLE_W-1]};
      fits     = trial >= {1'b0, dvs_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (ctrl.start_avg) begin
         // average arrives finished, no divider steps
         quo_in = avg;
         cnt_in = '0;
      end else if (ctrl.start_defl) begin
         // quotient fits in 8 bits, so 8 steps from the aligned remainder
         rem_in   = prod[DIVD_W-1:8];
         quo_in   = {prod[7:0], 4'b0};
         dvs_in   = below ? centre : (FULL_SCALE - centre);
         cnt_in   = DEFL_STEPS;
         lower_in = below;
         upper_in = above;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? SAMPLE_W'(trial - {1'b0, dvs_ff}) : trial[SAMPLE_W-1:0];
         quo_in = {quo_ff[SAMPLE_W-2:0], fits};
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
   end

   // signed deflection from the last quotient
   always_comb begin
      busy = cnt_ff != '0;
      qmag = {1'b0, quo_ff[7:0]};
      if (lower_ff) begin
         deflection = signed'(qmag - SPAN);
      end else if (upper_ff) begin
         deflection = signed'(qmag);
      end else begin
         deflection = '0;
      end
   end

endmodule

[rtl/joystick_axis_average_deadzone_top.sv]
// Top level of the joystick axis average and dead band block.
//
// Takes one word of four 12-bit joystick samples, adds it to a moving window of
// WINDOW_LENGTH words per axis held in a synchronous ring memory, and returns
// one word of four signed 9-bit deflections (-255..255, zero in the dead band
// around each configured centre; the left axes are inverted before use).
// Each accepted word passes in order through one memory read, one update of the
// running totals, the latching of the averages (a reciprocal multiplication by
// the window length), the branch pick and divider load, 8 steps of the per-axis
// serial divider for the scaled deflection, and the load of the output register,
// which waits while a held result is not taken; the four axes run in parallel
// lanes. The next word is taken once the result sits in the output register, so
// words never overlap. The ring reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. Centres must be written on the csr port
// only while idle; the block itself does not check this.
module joystick_axis_average_deadzone_top #(
   parameter int WINDOW_LENGTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: sample_left_h, sample_left_v, sample_right_h, sample_right_v
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: axis_left_h, axis_left_v, axis_right_h, axis_right_v, 4 zero bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import jaad_pkg::*;

   localparam int TOT_W  = $clog2(WINDOW_LENGTH * 4095 + 1);
   localparam int PTR_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int WORD_W = SAMPLE_W * AXES;
   localparam int OUT_W  = AXIS_W * AXES;

   // reciprocal of the window length: m = ceil(2^S / W), S = TOT_W + ceil(log2 W),
   // exact floor for every TOT_W-bit total
   localparam int RCP_L  = $clog2(WINDOW_LENGTH);
   localparam int RCP_S  = TOT_W + RCP_L;
   localparam int RCP_W  = TOT_W + 1;
   localparam int PROD_W = TOT_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_M =
      RCP_W'(((longint'(1) << RCP_S) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH));

   state_type state_ff, state_in;

   logic [WORD_W-1:0]   ring_mem [WINDOW_LENGTH];
   logic [WORD_W-1:0]   ring_rd_ff;
   logic                valid_rd_ff;
   logic [WORD_W-1:0]   samp_ff;
   logic [WINDOW_LENGTH-1:0] valid_ff, valid_in;
   logic [PTR_W-1:0]    pos_ff, pos_in;
   logic [TOT_W-1:0]    tot_ff [AXES];
   logic [TOT_W-1:0]    tot_in [AXES];
   logic [SAMPLE_W-1:0] centre_ff [AXES];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_data_ff;

   logic                req_accept;
   logic                ring_we;
   logic                rsp_load;
   lane_ctrl_type       lane_ctrl;
   logic [AXES-1:0]     busy_vec;
   logic                busy;
   logic [OUT_W-1:0]    defl_word;
   logic [PROD_W-1:0]   avg_prod [AXES];
   logic [SAMPLE_W-1:0] avg [AXES];

   assign req_accept = req_tvalid && req_tready;
   assign busy       = |busy_vec;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_accept) state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_AVG_GO;
         ST_AVG_GO:   state_in = ST_AVG_RUN;
         ST_AVG_RUN:  if (!busy) state_in = ST_DEFL_RUN;
         ST_DEFL_RUN: if (!busy) state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready           = 1'b0;
      ring_we              = 1'b0;
      lane_ctrl.start_avg  = 1'b0;
      lane_ctrl.start_defl = 1'b0;
      rsp_load             = 1'b0;
      case (state_ff)
         ST_IDLE:     req_tready = 1'b1;
         ST_UPDATE:   ring_we = 1'b1;
         ST_AVG_GO:   lane_ctrl.start_avg = 1'b1;
         ST_AVG_RUN:  lane_ctrl.start_defl = !busy;
         ST_DEFL_RUN: ;
         ST_DONE:     rsp_load = !rsp_valid_ff || rsp_tready;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ring memory: read the oldest word on accept, write the new one on update
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_rd_ff  <= ring_mem[pos_ff];
         valid_rd_ff <= valid_ff[pos_ff];
         samp_ff     <= req_tdata;
      end
      if (ring_we) begin
         ring_mem[pos_ff] <= samp_ff;
      end
   end

   // running totals, write slot and valid bits
   always_comb begin
      logic [SAMPLE_W-1:0] old_s;
      logic [SAMPLE_W-1:0] new_s;
      valid_in = valid_ff;
      pos_in   = pos_ff;
      for (int k = 0; k < AXES; k++) begin
         old_s     = valid_rd_ff ? ring_rd_ff[k*SAMPLE_W +: SAMPLE_W] : '0;
         new_s     = samp_ff[k*SAMPLE_W +: SAMPLE_W];
         tot_in[k] = tot_ff[k];
         if (ring_we) begin
            tot_in[k] = tot_ff[k] - TOT_W'(old_s) + TOT_W'(new_s);
         end
      end
      if (ring_we) begin
         valid_in[pos_ff] = 1'b1;
         pos_in = (pos_ff == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pos_ff   <= '0;
         for (int k = 0; k < AXES; k++) begin
            tot_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         for (int k = 0; k < AXES; k++) begin
            tot_ff[k] <= tot_in[k];
         end
      end
   end

   // averages: total / WINDOW_LENGTH rounded down, by reciprocal multiplication
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         avg_prod[k] = PROD_W'(tot_ff[k]) * PROD_W'(RCP_M);
         avg[k]      = avg_prod[k][RCP_S +: SAMPLE_W];
      end
   end

   // centre registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AXES; k++) begin
            centre_ff[k] <= CENTRE_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTRE_LEFT_H:  centre_ff[0] <= csr_data;
            CSR_CENTRE_LEFT_V:  centre_ff[1] <= csr_data;
            CSR_CENTRE_RIGHT_H: centre_ff[2] <= csr_data;
            CSR_CENTRE_RIGHT_V: centre_ff[3] <= csr_data;
            default:            ;
         endcase
      end
   end

   // one arithmetic lane per axis, left axes inverted
   for (genvar g = 0; g < AXES; g++) begin : g_lane
      logic signed [AXIS_W-1:0] defl;
      jaad_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .avg        (avg[g]),
         .centre     (centre_ff[g]),
         .invert     ((g < 2) ? 1'b1 : 1'b0),
         .busy       (busy_vec[g]),
         .deflection (defl)
      );
      assign defl_word[g*AXIS_W +: AXIS_W] = defl;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= defl_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

endmodule

[tb/tb_joystick_axis_average_deadzone_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the joystick axis average and dead band block.
module tb_joystick_axis_average_deadzone_top;
   import jaad_pkg::*;

   localparam int WIN             = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int LONG_HOLD       = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int WORDS_PER_PHASE = 150;
   localparam int SETTLE_CYCLES   = 40;

   typedef logic signed [AXIS_W-1:0] defl_type;

   // lowest bits first: left h, left v, right h, right v
   typedef struct packed {
      defl_type right_v;
      defl_type right_h;
      defl_type left_v;
      defl_type left_h;
   } deflections_type;

   typedef struct {
      logic [47:0]     samples;
      bit              reconfig;
      logic [47:0]     centres;
      bit              typed;
      deflections_type result;
   } stim_row_type;

   typedef enum int {SEG_NOISE, SEG_REST, SEG_PINNED, SEG_WOBBLE} segment_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // sample_left_h, sample_left_v, sample_right_h, sample_right_v
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // axis_left_h, axis_left_v, axis_right_h, axis_right_v, 4 zero bits
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   joystick_axis_average_deadzone_top #(.WINDOW_LENGTH(WIN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: sample window, running sums, write slot, centres
   logic [SAMPLE_W-1:0] window_mem [WIN][AXES];
   int                  axis_sum [AXES];
   int                  write_slot;
   logic [SAMPLE_W-1:0] centre [AXES];

   deflections_type awaited_deflections [$];
   stim_row_type    directed [$];
   int              error_count   = 0;
   int              words_sent    = 0;
   int              words_checked = 0;
   int              settings_used = 0;
   int              cycle_count   = 0;
   bit              idle_on       = 1'b1;
   bit              hold_request  = 1'b0;

   // dead band and scaling of one averaged axis
   function automatic int scale_axis(int v, int c);
      if (v < c - 1)
         return (v * int'(SPAN)) / c - int'(SPAN);
      if (v > c + 1)
         return ((v - c) * int'(SPAN)) / (int'(FULL_SCALE) - c);
      return 0;
   endfunction

   // push one sample word into the window and compute the deflections
   function automatic deflections_type predict_deflections(logic [47:0] word);
      int       avg;
      defl_type d [AXES];
      for (int k = 0; k < AXES; k++) begin
         axis_sum[k] = axis_sum[k] - int'(window_mem[write_slot][k])
                       + int'(word[k*SAMPLE_W +: SAMPLE_W]);
         window_mem[write_slot][k] = word[k*SAMPLE_W +: SAMPLE_W];
      end
      write_slot = (write_slot + 1) % WIN;
      for (int k = 0; k < AXES; k++) begin
         avg = axis_sum[k] / WIN;
         if (k < 2)
            avg = int'(FULL_SCALE) - avg;   // left axes are inverted
         d[k] = defl_type'(scale_axis(avg, int'(centre[k])));
      end
      return {d[3], d[2], d[1], d[0]};
   endfunction

   function automatic deflections_type defl(int lh, int lv, int rh, int rv);
      return {defl_type'(rv), defl_type'(rh), defl_type'(lv), defl_type'(lh)};
   endfunction

   function automatic void add_row(logic [47:0] s, bit reconfig, logic [47:0] c, bit typed,
                                   deflections_type r);
      directed.push_back('{s, reconfig, c, typed, r});
   endfunction

   function automatic int clamp12(int x);
      if (x < 0)
         return 0;
      if (x > int'(FULL_SCALE))
         return int'(FULL_SCALE);
      return x;
   endfunction

   function automatic void check_field(string name, defl_type exp, defl_type act);
      if (act !== exp) begin
         error_count++;
         $error("%s: expected %0d, got %0d", name, exp, act);
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_rsp
      deflections_type got;
      deflections_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[35:0];
         if (awaited_deflections.size() == 0) begin
            error_count++;
            $error("result word %h with none expected", rsp_tdata);
         end else begin
            exp = awaited_deflections.pop_front();
            check_field("axis_left_h", exp.left_h, got.left_h);
            check_field("axis_left_v", exp.left_v, got.left_v);
            check_field("axis_right_h", exp.right_h, got.right_h);
            check_field("axis_right_v", exp.right_v, got.right_v);
            words_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL joystick_axis_average_deadzone_top");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_request = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [1:0] index, logic [11:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      centre[index] = value;
   endtask

   // centres packed like a sample word: left h in the lowest bits
   task automatic set_centres(logic [47:0] c);
      csr_write(CSR_CENTRE_RIGHT_V, c[47:36]);
      csr_write(CSR_CENTRE_LEFT_H, c[11:0]);
      csr_write(CSR_CENTRE_RIGHT_H, c[35:24]);
      csr_write(CSR_CENTRE_LEFT_V, c[23:12]);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // offer one word, optionally after a gap; predict once it is taken
   task automatic send_word(logic [47:0] w, bit typed, deflections_type known);
      int              gap;
      deflections_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_deflections(w);
      awaited_deflections.push_back(typed ? known : predicted);
      words_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_deflections.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [47:0]      word;
      logic [47:0]      cw;
      segment_kind_type seg_kind;
      int               seg_left;
      int               seg_val [AXES];
      int               s;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_CENTRE_LEFT_H;
      csr_data   = '0;

      for (int r = 0; r < WIN; r++)
         for (int k = 0; k < AXES; k++)
            window_mem[r][k] = '0;
      for (int k = 0; k < AXES; k++) begin
         axis_sum[k] = 0;
         centre[k]   = CENTRE_RESET;
      end
      write_slot = 0;

      // directed rows: warm-up from the cleared window at reset centres,
      // then extreme centres where one branch of the scaling is impossible
      add_row(48'h000_000_000_000, 1'b0, '0, 1'b1, defl(255, 255, -255, -255));
      repeat (15) add_row(48'hFFF_FFF_FFF_FFF, 1'b0, '0, 1'b0, '0);
      add_row(48'hFFF_FFF_FFF_FFF, 1'b0, '0, 1'b1, defl(-255, -255, 255, 255));
      add_row(48'hFFF_000_AAA_555, 1'b0, '0, 1'b0, '0);
      add_row(48'h000_000_000_000, 1'b1, {12'd4095, 12'd4094, 12'd1, 12'd0}, 1'b0, '0);
      add_row(48'hFFF_000_FFF_000, 1'b0, '0, 1'b0, '0);
      add_row(48'hAAA_555_AAA_555, 1'b0, '0, 1'b0, '0);
      add_row(48'h555_AAA_555_AAA, 1'b0, '0, 1'b0, '0);
      add_row(48'h800_7FF_800_7FF, 1'b1, {12'd1, 12'd0, 12'd4094, 12'd4095}, 1'b0, '0);
      add_row(48'h000_FFF_000_FFF, 1'b0, '0, 1'b0, '0);
      add_row(48'h123_456_789_ABC, 1'b0, '0, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].reconfig) begin
            drain();
            set_centres(directed[i].centres);
         end
         send_word(directed[i].samples, directed[i].typed, directed[i].result);
      end

      // random phases, each under its own set of centres
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         case (p)
            1: cw = {12'd0, 12'd1, 12'd4094, 12'd4095};
            2: cw = {4{CENTRE_RESET}};
            4: cw = {12'd4095, 12'd4094, 12'd1, 12'd0};
            default: begin
               for (int k = 0; k < AXES; k++)
                  cw[k*SAMPLE_W +: SAMPLE_W] = 12'($urandom_range(0, 4095));
            end
         endcase
         set_centres(cw);
         idle_on  = (p < RANDOM_PHASES - 1);
         seg_left = 0;
         seg_kind = SEG_NOISE;
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (p == 1 && i == 40)
               hold_request = 1'b1;
            // a segment holds the sticks still near the centre or at a stop, wobbles them, or sends noise
            if (seg_left == 0) begin
               seg_kind = segment_kind_type'($urandom_range(0, 3));
               seg_left = $urandom_range(1, 24);
               for (int k = 0; k < AXES; k++) begin
                  case (seg_kind)
                     SEG_REST: begin
                        s = clamp12(int'(centre[k]) + $urandom_range(0, 6) - 3);
                        seg_val[k] = (k < 2) ? int'(FULL_SCALE) - s : s;
                     end
                     SEG_PINNED: seg_val[k] = $urandom_range(0, 1) ? int'(FULL_SCALE) : 0;
                     default:    seg_val[k] = $urandom_range(0, 4095);
                  endcase
               end
            end
            for (int k = 0; k < AXES; k++) begin
               case (seg_kind)
                  SEG_NOISE:  s = $urandom_range(0, 4095);
                  SEG_WOBBLE: s = clamp12(seg_val[k] + $urandom_range(0, 8) - 4);
                  default:    s = seg_val[k];
               endcase
               word[k*SAMPLE_W +: SAMPLE_W] = 12'(s);
            end
            seg_left--;
            send_word(word, 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d sample words and %0d checked results under %0d centre settings,",
               words_sent, words_checked, settings_used + 1);
      $display("including window warm-up, extreme centres, dead band edges and a long stall.");
      if (error_count == 0)
         $display("PASS joystick_axis_average_deadzone_top");
      else
         $display("FAIL joystick_axis_average_deadzone_top");
      $finish;
   end

endmodule

[joystick_axis_average_deadzone_top.f]
rtl/jaad_pkg.sv
rtl/jaad_lane.sv
rtl/joystick_axis_average_deadzone_top.sv
tb/tb_joystick_axis_average_deadzone_top.sv
